@@ rtl/spq_pkg.sv @@
// shared types, codes and constants of the stable priority queue
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    // request commands
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DEQUEUED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   patient_id;
        logic [PRIO_W-1:0] priority_req;
    } spq_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   served_id;
        logic [PRIO_W-1:0] served_priority;
        logic [OCC_W-1:0]  occupancy;
    } spq_rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } spq_entry_t;

    localparam int ENTRY_W = $bits(spq_entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ_READ,
        ST_ENQ_CMP,
        ST_DEQ_READ,
        ST_DEQ_CAP,
        ST_DONE
    } spq_state_t;

endpackage

@@ rtl/stable_priority_queue_core.sv @@
// top level of the stable priority queue: request port, core and response register
// Bounded queue of (id, priority) entries kept in descending priority order;
// an entry of equal priority goes behind those already held, so equal
// priorities leave first-in first-out. A request with command enqueue
// inserts the entry (status full and no change when QUEUE_DEPTH entries are
// held); command dequeue returns the front entry (status empty when none).
// Every request gives exactly one response, which carries the occupancy after
// the request. Entries live in one ram addressed as a ring from a head
// pointer, so a dequeue moves nothing; an enqueue walks from the tail toward
// the head through a single read port and a single priority comparator,
// moving each lower-priority entry one slot back.
// Steps: a dequeue reads the head slot (ST_DEQ_READ) and captures it
// (ST_DEQ_CAP); full or empty goes straight to ST_DONE; an enqueue alternates
// ST_ENQ_READ and ST_ENQ_CMP, moving each held entry of strictly lower priority,
// then writes the new entry; the response waits in ST_DONE until it is taken.
// A new request is
// taken only while the sequencer is idle, which is once the finished
// response has moved into the response register; that register lets the
// next request start while the previous response is still stalled.
module stable_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_stall,
    input  spq_pkg::spq_req_t req,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output spq_pkg::spq_rsp_t rsp
);

    import spq_pkg::*;

    logic     core_ready;
    logic     res_valid;
    logic     res_ready;
    spq_rsp_t res;

    logic     rsp_valid_reg, rsp_valid_next;
    spq_rsp_t rsp_reg, rsp_next;

    assign req_stall = !core_ready;

    // sequencer with the entry ring and the shared compare unit
    spq_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (core_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // response register loads whenever it is empty or being drained
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
            if (res_valid)
            begin
                rsp_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/spq_ram.sv @@
// generic single-write, single-read ram with registered read data
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/spq_core.sv @@
// sequencer, shared address and compare unit, and entry store of the queue
module spq_core #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  spq_pkg::spq_req_t req,
    output logic              res_valid,
    input  logic              res_ready,
    output spq_pkg::spq_rsp_t res
);

    import spq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);

    spq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    spq_entry_t       new_reg, new_next;
    spq_rsp_t         res_reg, res_next;

    logic             accept;
    logic [IDX_W-1:0] logical_idx;
    logic [IDX_W:0]   addr_sum;
    logic [IDX_W-1:0] phys_addr;
    logic             ram_we;
    spq_entry_t       ram_wdata;
    spq_entry_t       ram_rdata;
    logic             slot_found;

    assign accept = req_valid && req_ready;

    // shared circular address unit: head plus logical slot, wrapped once
    always_comb
    begin
        case (state_reg)
            ST_ENQ_READ: logical_idx = (pos_reg == '0) ? pos_reg : pos_reg - 1'b1;
            ST_DEQ_READ: logical_idx = '0;
            default:     logical_idx = pos_reg;
        endcase
    end

    always_comb
    begin
        addr_sum = {1'b0, head_reg} + {1'b0, logical_idx};
        if (addr_sum >= DEPTH_EXT)
        begin
            addr_sum = addr_sum - DEPTH_EXT;
        end
        phys_addr = addr_sum[IDX_W-1:0];
    end

    // shared compare: held entry stays ahead when its priority is equal or greater
    assign slot_found = (ram_rdata.prio >= new_reg.prio);

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (phys_addr),
        .wr_data (ram_wdata),
        .rd_addr (phys_addr),
        .rd_data (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == CMD_ENQUEUE)
                    begin
                        state_next = (count_reg == CNT_FULL) ? ST_DONE : ST_ENQ_READ;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_DONE : ST_DEQ_READ;
                    end
                end
            end
            ST_ENQ_READ: state_next = (pos_reg == '0) ? ST_DONE : ST_ENQ_CMP;
            ST_ENQ_CMP:  state_next = slot_found ? ST_DONE : ST_ENQ_READ;
            ST_DEQ_READ: state_next = ST_DEQ_CAP;
            ST_DEQ_CAP:  state_next = ST_DONE;
            ST_DONE:     state_next = res_ready ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and store controls
    always_comb
    begin
        req_ready = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = new_reg;
        case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_ENQ_READ:
            begin
                ram_we = (pos_reg == '0);
            end
            ST_ENQ_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = slot_found ? new_reg : ram_rdata;
            end
            ST_DONE: res_valid = 1'b1;
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        pos_next   = pos_reg;
        new_next   = new_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    new_next.id   = req.patient_id;
                    new_next.prio = req.priority_req;
                    pos_next      = IDX_W'(count_reg);
                    res_next.served_id       = '0;
                    res_next.served_priority = '0;
                    res_next.occupancy       = OCC_W'(count_reg);
                    if (req.command == CMD_ENQUEUE)
                    begin
                        res_next.status = (count_reg == CNT_FULL) ? STAT_FULL : STAT_ENQUEUED;
                    end
                    else
                    begin
                        res_next.status = (count_reg == '0) ? STAT_EMPTY : STAT_DEQUEUED;
                    end
                end
            end
            ST_ENQ_READ:
            begin
                if (pos_reg == '0)
                begin
                    count_next         = count_reg + 1'b1;
                    res_next.occupancy = OCC_W'(count_reg + 1'b1);
                end
            end
            ST_ENQ_CMP:
            begin
                if (slot_found)
                begin
                    count_next         = count_reg + 1'b1;
                    res_next.occupancy = OCC_W'(count_reg + 1'b1);
                end
                else
                begin
                    pos_next = pos_reg - 1'b1;
                end
            end
            ST_DEQ_CAP:
            begin
                res_next.served_id       = ram_rdata.id;
                res_next.served_priority = ram_rdata.prio;
                res_next.occupancy       = OCC_W'(count_reg - 1'b1);
                count_next               = count_reg - 1'b1;
                head_next                = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        new_reg <= new_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
